// ----- rtl/tcpd_pkg.sv -----
// Shared types, character codes and lookup tables for the text column to PWM duty block.
package tcpd_pkg;

   // Width of the PWM duty word and its full-scale value.
   localparam int DUTY_BITS = 13;
   localparam int DutyMax   = (1 << DUTY_BITS) - 1;
   localparam int PctFull   = 100;

   // Character codes that steer the tokenizer.
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Pending sign codes.
   localparam logic [1:0] SIGN_NONE  = 2'd0;
   localparam logic [1:0] SIGN_PLUS  = 2'd1;
   localparam logic [1:0] SIGN_MINUS = 2'd2;

   // Token count at which the third token is being read, and its saturation value.
   localparam logic [1:0] TOKEN_THIRD = 2'd2;
   localparam logic [1:0] TOKEN_FULL  = 2'd3;

   // Level of the third token: 0 to 8 are table entries, 9 marks out of range.
   localparam logic [3:0] LEVEL_TOP = 4'd8;
   localparam logic [3:0] LEVEL_OUT = 4'd9;

   typedef logic [DUTY_BITS-1:0] duty_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_payload_type;

   typedef struct packed {
      duty_type   duty;
      logic [6:0] lamp_pct;
      logic       source_valid;
   } rsp_payload_type;

   // Inverted duty for a brightness percent, evaluated at elaboration only.
   function automatic duty_type duty_calc(input int pct);
      int d;
      d = DutyMax - (DutyMax * pct) / PctFull;
      return d[DUTY_BITS-1:0];
   endfunction

   // Brightness percent per level; every level above 8 reads as zero.
   localparam logic [6:0] PCT_TABLE [16] = '{
      7'd0, 7'd20, 7'd30, 7'd35, 7'd40, 7'd50, 7'd55, 7'd60, 7'd70,
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
   };

   localparam duty_type DUTY_TABLE [16] = '{
      duty_calc(0),  duty_calc(20), duty_calc(30), duty_calc(35),
      duty_calc(40), duty_calc(50), duty_calc(55), duty_calc(60),
      duty_calc(70), duty_calc(0),  duty_calc(0),  duty_calc(0),
      duty_calc(0),  duty_calc(0),  duty_calc(0),  duty_calc(0)
   };

endpackage

// ----- rtl/tcpd_stream_if.sv -----
// Valid/ready stream interface that carries one payload beat per handshake.
interface tcpd_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/text_column_to_pwm_duty.sv -----
// Top level: tokenizes a text stream and turns the third number of each line into a PWM duty.
// A beat accepted on req_chan enters the input register; its result is then registered in
// the result register that drives rsp_chan. Throughput: one byte per cycle while rsp_chan
// does not stall, set by the tokenizer update between the input and result registers;
// lines with fewer than three tokens produce no result.
// Reset is synchronous and active high; it clears the line state and both valid flags.
module text_column_to_pwm_duty
   import tcpd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   tcpd_stream_if.sink   req_chan,
   tcpd_stream_if.source rsp_chan
);

   // Input register: holds one accepted beat until the tokenizer consumes it.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] byte_ff,     byte_in;
   logic       eot_ff,      eot_in;

   // Line state of the tokenizer.
   logic [1:0] token_count_ff,     token_count_in;
   logic [1:0] sign_pending_ff,    sign_pending_in;
   logic       in_number_ff,       in_number_in;
   logic       number_negative_ff, number_negative_in;
   logic [3:0] magnitude_ff,       magnitude_in;
   logic [3:0] third_level_ff,     third_level_in;

   // Result register.
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff,  rsp_data_in;

   // The tokenizer stage moves whenever the result register is free or is being emptied.
   logic advance;
   logic step;
   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign step    = in_valid_ff && advance;

   assign req_chan.ready   = !in_valid_ff || advance;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // Byte classification.
   logic is_break, is_digit, is_sign, closing;
   logic [3:0] digit;
   assign is_break = (byte_ff == CHAR_LF) || (byte_ff == CHAR_CR);
   assign is_digit = (byte_ff >= CHAR_ZERO) && (byte_ff <= CHAR_NINE);
   assign is_sign  = (byte_ff == CHAR_PLUS) || (byte_ff == CHAR_MINUS);
   // The ASCII digits sit at 0x30 to 0x39, so the low nibble is the digit value.
   assign digit    = byte_ff[3:0];
   // A line closes at a break, and after the last byte of the text.
   assign closing  = is_break || eot_ff;

   // Token count after ending any open token.
   logic [1:0] ended_count;
   assign ended_count = (in_number_ff && token_count_ff != TOKEN_FULL) ?
                        token_count_ff + 2'd1 : token_count_ff;

   // State after the byte itself, before any line close.
   logic [1:0] post_count, post_sign, final_count;
   logic       post_in_number, post_negative;
   logic [3:0] post_magnitude, post_level, start_mag, next_mag;
   logic       start_negative;

   always_comb begin
      // A digit either opens a token, taking the pending sign, or extends the open one.
      start_negative = in_number_ff ? number_negative_ff : (sign_pending_ff == SIGN_MINUS);
      start_mag      = in_number_ff ? magnitude_ff : 4'd0;
      // Times ten plus a digit saturates at nine as soon as anything nonzero is held.
      next_mag       = (start_mag == 4'd0) ? digit : LEVEL_OUT;

      post_count     = token_count_ff;
      post_sign      = sign_pending_ff;
      post_in_number = in_number_ff;
      post_negative  = number_negative_ff;
      post_magnitude = magnitude_ff;
      post_level     = third_level_ff;

      priority if (is_break) begin
         // A break only closes the line, handled below.
      end else if (is_digit) begin
         post_in_number = 1'b1;
         post_negative  = start_negative;
         post_sign      = SIGN_NONE;
         post_magnitude = start_mag;
         if (token_count_ff == TOKEN_THIRD) begin
            post_magnitude = next_mag;
            post_level     = (start_negative && next_mag != 4'd0) ? LEVEL_OUT : next_mag;
         end
      end else if (is_sign) begin
         post_count     = ended_count;
         post_in_number = 1'b0;
         post_sign      = (byte_ff == CHAR_MINUS) ? SIGN_MINUS : SIGN_PLUS;
      end else begin
         post_count     = ended_count;
         post_in_number = 1'b0;
         post_sign      = SIGN_NONE;
      end

      // Closing a line first ends the token that is still open.
      final_count = (post_in_number && post_count != TOKEN_FULL) ?
                    post_count + 2'd1 : post_count;
   end

   // Next-state logic for the input register, line state and result register.
   always_comb begin
      in_valid_in = in_valid_ff;
      byte_in     = byte_ff;
      eot_in      = eot_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         byte_in     = req_chan.payload.text_byte;
         eot_in      = req_chan.payload.end_of_text;
      end

      token_count_in     = token_count_ff;
      sign_pending_in    = sign_pending_ff;
      in_number_in       = in_number_ff;
      number_negative_in = number_negative_ff;
      magnitude_in       = magnitude_ff;
      third_level_in     = third_level_ff;
      if (step) begin
         if (closing) begin
            token_count_in     = 2'd0;
            sign_pending_in    = SIGN_NONE;
            in_number_in       = 1'b0;
            number_negative_in = 1'b0;
            magnitude_in       = 4'd0;
            third_level_in     = 4'd0;
         end else begin
            token_count_in     = post_count;
            sign_pending_in    = post_sign;
            in_number_in       = post_in_number;
            number_negative_in = post_negative;
            magnitude_in       = post_magnitude;
            third_level_in     = post_level;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         // A result is produced only when a line with at least three tokens closes.
         rsp_valid_in               = step && closing && (final_count == TOKEN_FULL);
         rsp_data_in.duty           = DUTY_TABLE[post_level];
         rsp_data_in.lamp_pct       = PCT_TABLE[post_level];
         rsp_data_in.source_valid   = (post_level <= LEVEL_TOP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         token_count_ff     <= 2'd0;
         sign_pending_ff    <= SIGN_NONE;
         in_number_ff       <= 1'b0;
         number_negative_ff <= 1'b0;
         magnitude_ff       <= 4'd0;
         third_level_ff     <= 4'd0;
      end else begin
         in_valid_ff        <= in_valid_in;
         rsp_valid_ff       <= rsp_valid_in;
         token_count_ff     <= token_count_in;
         sign_pending_ff    <= sign_pending_in;
         in_number_ff       <= in_number_in;
         number_negative_ff <= number_negative_in;
         magnitude_ff       <= magnitude_in;
         third_level_ff     <= third_level_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      eot_ff      <= eot_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   // An out-of-range third token always gives zero brightness and full inverted duty.
   a_invalid_is_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.source_valid) |->
      (rsp_data_ff.lamp_pct == 7'd0 && rsp_data_ff.duty == duty_type'(DutyMax)))
      else $error("out-of-range token produced nonzero brightness");

   // Closing a line leaves the tokenizer with no open token and no pending sign.
   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      (step && closing) |=>
      (token_count_ff == 2'd0 && sign_pending_ff == SIGN_NONE && !in_number_ff))
      else $error("line state not cleared after line end");

   // The saturating magnitude and the level never pass the out-of-range mark.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      (magnitude_ff <= LEVEL_OUT) && (third_level_ff <= LEVEL_OUT))
      else $error("magnitude or level above saturation");

   // A result appears only after the tokenizer consumed a closing beat.
   a_result_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step && closing))
      else $error("result without a line end");

   // A sign is never pending while a token is open.
   a_sign_open: assert property (@(posedge clock) disable iff (reset)
      in_number_ff |-> (sign_pending_ff == SIGN_NONE))
      else $error("pending sign inside a token");
`endif

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for text_column_to_pwm_duty: byte stream stimulus and duty prediction.
`timescale 1ns / 100ps

module tb_top
   import tcpd_pkg::*;
();

   // Cycles without any accepted beat after which the run is declared hung. The slowest
   // legitimate stretch comes from random stalls, so this is generous.
   localparam int QuietLimit = 1000;

   // Cumulative byte counts at which each idling phase ends.
   localparam int PhaseOneEnd   = 533;
   localparam int PhaseTwoEnd   = 1066;
   localparam int PhaseThreeEnd = 1600;

   // Predicts the result of every line that the block closes and checks the results that
   // come back, in order, against those predictions.
   class duty_scoreboard;
      rsp_payload_type pending_q[$];
      int              error_count;

      // Private copy of the tokenizer state.
      logic [1:0] tokens_done;
      logic [1:0] sign_seen;
      bit         reading_digits;
      bit         minus_token;
      logic [3:0] third_mag;
      logic [3:0] third_lvl;

      function new();
         error_count = 0;
         clear_line();
      endfunction

      function void clear_line();
         tokens_done    = 2'd0;
         sign_seen      = SIGN_NONE;
         reading_digits = 1'b0;
         minus_token    = 1'b0;
         third_mag      = 4'd0;
         third_lvl      = 4'd0;
      endfunction

      function void finish_token();
         if (reading_digits) begin
            if (tokens_done < TOKEN_FULL) begin
               tokens_done = tokens_done + 2'd1;
            end
            reading_digits = 1'b0;
         end
      endfunction

      function int level_pct(logic [3:0] lvl);
         unique case (lvl)
            4'd1: return 20;
            4'd2: return 30;
            4'd3: return 35;
            4'd4: return 40;
            4'd5: return 50;
            4'd6: return 55;
            4'd7: return 60;
            4'd8: return 70;
            default: return 0;
         endcase
      endfunction

      // Closes the line; queues a duty if the line held a third token.
      function bit close_line();
         rsp_payload_type want;
         int              pct;
         bit              in_range;
         bit              made;
         finish_token();
         made = (tokens_done == TOKEN_FULL);
         if (made) begin
            in_range            = (third_lvl <= LEVEL_TOP);
            pct                 = in_range ? level_pct(third_lvl) : 0;
            want.duty           = duty_type'(DutyMax - (DutyMax * pct) / PctFull);
            want.lamp_pct       = 7'(pct);
            want.source_valid   = in_range;
            pending_q.push_back(want);
         end
         clear_line();
         return made;
      endfunction

      function void note_input(req_payload_type beat);
         int         grown;
         logic [3:0] digit;
         bit         made;
         made = 1'b0;
         if (beat.text_byte == CHAR_LF || beat.text_byte == CHAR_CR) begin
            made = close_line();
         end else if (beat.text_byte >= CHAR_ZERO && beat.text_byte <= CHAR_NINE) begin
            digit = 4'(beat.text_byte - CHAR_ZERO);
            if (!reading_digits) begin
               reading_digits = 1'b1;
               minus_token    = (sign_seen == SIGN_MINUS);
               third_mag      = 4'd0;
               sign_seen      = SIGN_NONE;
            end
            if (tokens_done == TOKEN_THIRD) begin
               grown     = int'(third_mag) * 10 + int'(digit);
               third_mag = (grown > int'(LEVEL_OUT)) ? LEVEL_OUT : 4'(grown);
               third_lvl = (minus_token && third_mag != 4'd0) ? LEVEL_OUT : third_mag;
            end
         end else if (beat.text_byte == CHAR_PLUS || beat.text_byte == CHAR_MINUS) begin
            finish_token();
            sign_seen = (beat.text_byte == CHAR_MINUS) ? SIGN_MINUS : SIGN_PLUS;
         end else begin
            finish_token();
            sign_seen = SIGN_NONE;
         end
         // The final byte of a text closes its line once, even if that byte was a break.
         if (beat.end_of_text && !made) begin
            void'(close_line());
         end
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_q.size() == 0) begin
            $error("unexpected result: duty %0d, lamp_pct %0d, source_valid %0d",
                   got.duty, got.lamp_pct, got.source_valid);
            error_count++;
         end else begin
            want = pending_q.pop_front();
            if (got.duty !== want.duty) begin
               $error("duty: expected %0d, actual %0d", want.duty, got.duty);
               error_count++;
            end
            if (got.lamp_pct !== want.lamp_pct) begin
               $error("lamp_pct: expected %0d, actual %0d",
                      want.lamp_pct, got.lamp_pct);
               error_count++;
            end
            if (got.source_valid !== want.source_valid) begin
               $error("source_valid: expected %0d, actual %0d",
                      want.source_valid, got.source_valid);
               error_count++;
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   tcpd_stream_if #(.payload_type(req_payload_type)) req_chan ();
   tcpd_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   text_column_to_pwm_duty dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   duty_scoreboard sb = new();

   // Percent of cycles in which the sender holds back a beat and the receiver refuses one.
   int send_idle_pct;
   int recv_stall_pct;
   int beats_sent;
   int quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver refuses results at random, at the rate set for the current phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor and watchdog. Values read right after the edge are those that the edge saw,
   // since every testbench driver uses nonblocking assignments. A result is always loaded into
   // the result register from a byte already held in the input register, so checking results
   // before noting inputs within one edge is safe.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            sb.check_result(rsp_chan.payload);
         end
         if (req_chan.valid && req_chan.ready) begin
            sb.note_input(req_chan.payload);
         end
         if ((rsp_chan.valid && rsp_chan.ready) || (req_chan.valid && req_chan.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles = quiet_cycles + 1;
         end
         if (quiet_cycles >= QuietLimit) begin
            $display("text_column_to_pwm_duty verification failed");
            $finish;
         end
      end
   end

   // Offers one byte, with a random gap in front, and holds it until the block takes it.
   // Valid stays high straight into the next beat when no gap is drawn.
   task automatic send_byte(input logic [7:0] text_byte, input bit last_of_text);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= req_payload_type'{text_byte, last_of_text};
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      beats_sent++;
   endtask

   task automatic send_string(input string text, input bit eot_on_last);
      for (int i = 0; i < text.len(); i++) begin
         send_byte(text[i], eot_on_last && (i == text.len() - 1));
      end
   endtask

   // A byte that separates tokens: mostly ordinary punctuation, sometimes any other byte
   // that is neither a digit, a sign nor a line break.
   function automatic logic [7:0] pick_separator();
      string      common;
      logic [7:0] pick;
      common = " ,;\t:";
      if ($urandom_range(3) != 0) begin
         return common[$urandom_range(common.len() - 1)];
      end
      pick = 8'($urandom_range(255));
      while ((pick >= CHAR_ZERO && pick <= CHAR_NINE) || pick == CHAR_PLUS ||
             pick == CHAR_MINUS || pick == CHAR_LF || pick == CHAR_CR) begin
         pick = 8'($urandom_range(255));
      end
      return pick;
   endfunction

   // Sends one line of mostly well-formed numbers. The third token leans toward the
   // table range so that every brightness step shows up, while signs, long numbers,
   // dropped signs and stray bytes keep the tokenizer honest.
   task automatic send_random_line();
      logic [7:0] text_q[$];
      int         token_total;
      int         sign_total;
      int         digit_total;
      int         ending;
      bit         eot_on_last;
      token_total = ($urandom_range(9) < 7) ? $urandom_range(3, 5) : $urandom_range(0, 2);
      for (int t = 0; t < token_total; t++) begin
         sign_total = $urandom_range(9);
         sign_total = (sign_total < 5) ? 0 : (sign_total < 8) ? 1 : 2;
         // A sign right after digits splits the tokens by itself, so the separator
         // may then be left out.
         if (t > 0 && !(sign_total > 0 && $urandom_range(1) == 1)) begin
            text_q.push_back(pick_separator());
         end
         for (int s = 0; s < sign_total; s++) begin
            text_q.push_back(($urandom_range(1) == 1) ? CHAR_MINUS : CHAR_PLUS);
         end
         // Now and then a sign is cut off from its digits and must be dropped.
         if (sign_total > 0 && $urandom_range(9) == 0) begin
            text_q.push_back(pick_separator());
         end
         digit_total = (t == 2 && $urandom_range(3) != 0) ? 1 : $urandom_range(1, 3);
         for (int d = 0; d < digit_total; d++) begin
            text_q.push_back(CHAR_ZERO + 8'($urandom_range(9)));
         end
         if ($urandom_range(19) == 0) begin
            text_q.push_back(8'($urandom_range(255)));
         end
      end
      ending      = $urandom_range(9);
      eot_on_last = (ending >= 8);
      unique case (ending)
         5: text_q.push_back(CHAR_CR);
         6: begin
            text_q.push_back(CHAR_CR);
            text_q.push_back(CHAR_LF);
         end
         7: begin
            text_q.push_back(CHAR_LF);
            text_q.push_back(CHAR_CR);
            text_q.push_back(CHAR_LF);
         end
         8: begin
            if (text_q.size() == 0) begin
               text_q.push_back(pick_separator());
            end
         end
         default: text_q.push_back(CHAR_LF);
      endcase
      foreach (text_q[i]) begin
         send_byte(text_q[i], eot_on_last && (i == text_q.size() - 1));
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      send_idle_pct    = 26;
      recv_stall_pct   = 75;
      beats_sent       = 0;
      quiet_cycles     = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed lines. The first has a sign pair where the last sign wins, a sign right
      // after digits, and minus zero as its third token, then an empty line behind it.
      send_string("9+-1-0\n\r", 1'b0);
      // A third token above the table range, closed by the final byte of the text.
      send_string("7 8 99", 1'b1);
      // The top table entry behind extreme separator bytes and a sign that a NUL drops;
      // the line break itself carries the end of text.
      send_string("1", 1'b0);
      send_byte(8'hFF, 1'b0);
      send_string("2-", 1'b0);
      send_byte(8'h00, 1'b0);
      send_string("8\n", 1'b1);

      // Random lines, in three idling phases.
      while (beats_sent < PhaseOneEnd) begin
         send_random_line();
      end
      send_idle_pct  = 75;
      recv_stall_pct = 26;
      while (beats_sent < PhaseTwoEnd) begin
         send_random_line();
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      while (beats_sent < PhaseThreeEnd) begin
         send_random_line();
      end
      req_chan.valid <= 1'b0;

      // Drain the expected results, then leave room for any stray beat to show up.
      while (sb.pending_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (sb.error_count == 0) begin
         $display("text_column_to_pwm_duty verification clean");
      end else begin
         $display("text_column_to_pwm_duty verification failed");
      end
      $finish;
   end

endmodule
